// File: hdl/qa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qa_pkg
// Shared types and constants for the Q24.8 fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package qa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;
  // dividend width after the fraction shift, also the number of divide steps
  localparam int QUO_W     = DATA_W + FRAC_BITS;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  // one item as it travels down the pipeline
  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic              dz;
    logic [DATA_W-1:0] res;   // result for every op but divide
    logic [DATA_W-1:0] rem;   // partial remainder
    logic [QUO_W-1:0]  num;   // dividend bits out, quotient bits in
    logic [DATA_W-1:0] den;   // divisor magnitude
  } pipe_t;

endpackage

// File: hdl/qa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qa_front
// Entry stage: decodes the opcode, computes the results of every op but
// divide (including the multiply) and prepares the divider operands.
// ----------------------------------------------------------------------------
module qa_front
  import qa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [3:0]        req_type,
  input  logic [DATA_W-1:0] operand_a,
  input  logic [DATA_W-1:0] operand_b,
  output logic              vout,
  output pipe_t             dout
);

  logic signed [DATA_W-1:0]   sa, sb;
  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]          abs_a, abs_b, rnd, res;
  logic                       lt, eq;
  op_t                        op;
  pipe_t                      d_next;

  assign sa   = operand_a;
  assign sb   = operand_b;
  assign op   = op_t'(req_type);
  assign lt   = sa < sb;
  assign eq   = operand_a == operand_b;
  assign prod = sa * sb;

  assign abs_a = sa[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
  assign abs_b = sb[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;
  // bias negatives so the arithmetic shift truncates toward zero
  assign rnd   = operand_a + (sa[DATA_W-1] ? DATA_W'((1 << FRAC_BITS) - 1) : '0);

  // results of every op but divide
  always_comb begin
    case (op)
      OP_ADD:      res = operand_a + operand_b;
      OP_SUB:      res = operand_a - operand_b;
      OP_MUL:      res = prod[DATA_W+FRAC_BITS-1:FRAC_BITS];
      OP_LT:       res = DATA_W'(lt);
      OP_GT:       res = DATA_W'(!lt && !eq);
      OP_LE:       res = DATA_W'(lt || eq);
      OP_GE:       res = DATA_W'(!lt);
      OP_EQ:       res = DATA_W'(eq);
      OP_NE:       res = DATA_W'(!eq);
      OP_MIN:      res = lt ? operand_a : operand_b;
      OP_MAX:      res = (!lt && !eq) ? operand_a : operand_b;
      OP_INC:      res = operand_a + 1'b1;
      OP_DEC:      res = operand_a - 1'b1;
      OP_FROM_INT: res = operand_a << FRAC_BITS;
      OP_TO_INT:   res = DATA_W'($signed(rnd) >>> FRAC_BITS);
      default:     res = '0;
    endcase
  end

  always_comb begin
    d_next.is_div = op == OP_DIV;
    d_next.neg    = sa[DATA_W-1] ^ sb[DATA_W-1];
    d_next.dz     = operand_b == '0;
    d_next.res    = res;
    d_next.rem    = '0;
    d_next.num    = {abs_a, {FRAC_BITS{1'b0}}};
    d_next.den    = abs_b;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

// File: hdl/qa_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qa_div_step
// One restoring-division stage: retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module qa_div_step
  import qa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vin,
  input  pipe_t din,
  output logic  vout,
  output pipe_t dout
);

  logic [DATA_W:0] sh, diff;
  logic            ge;
  pipe_t           d_next;

  // shift in the next dividend bit, trial subtract
  assign sh   = {din.rem, din.num[QUO_W-1]};
  assign diff = sh - {1'b0, din.den};
  assign ge   = sh >= {1'b0, din.den};

  always_comb begin
    d_next     = din;
    d_next.rem = ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
    d_next.num = {din.num[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

// File: hdl/qa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qa_back
// Output stage: applies the quotient sign, the divide-by-zero rule and
// selects the final result into the output register.
// ----------------------------------------------------------------------------
module qa_back
  import qa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  pipe_t             din,
  output logic              vout,
  output logic [DATA_W-1:0] result_value,
  output logic              divide_by_zero
);

  logic [DATA_W-1:0] q, val;
  logic              dz;

  assign q  = din.num[DATA_W-1:0];
  assign dz = din.is_div && din.dz;

  // final select
  always_comb begin
    if (!din.is_div) begin
      val = din.res;
    end else if (din.dz) begin
      val = '0;
    end else begin
      val = din.neg ? (~q + 1'b1) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      result_value   <= val;
      divide_by_zero <= dz;
    end
  end

endmodule

// File: hdl/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed Q24.8 fixed-point ALU, fully pipelined with a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Accepts one operation per clock while not stalled and returns one result per beat in order.
// Every operation passes through the same stages: one entry stage that
// computes all simple results and the multiply, 40 divider stages (one
// quotient bit each, 32 integer plus 8 fraction bits), and the output
// register. Stages hold independently, so bubbles close up while the output
// is stalled and input beats are still taken until the pipeline is full.
module fixed_point_q24_8_alu
  import qa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [3:0]        req_type,
  input  logic [DATA_W-1:0] operand_a,
  input  logic [DATA_W-1:0] operand_b,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [DATA_W-1:0] result_value,
  output logic              divide_by_zero
);

  localparam int LAST = QUO_W + 1;

  logic  v  [0:LAST];
  logic  en [0:LAST];
  pipe_t d  [0:QUO_W];

  // a stage moves when it is empty or the one after it moves
  assign en[LAST] = !v[LAST] || !rsp_stall;
  genvar i;
  generate
    for (i = 0; i < LAST; i++) begin : g_en
      assign en[i] = !v[i] || en[i+1];
    end
  endgenerate

  assign req_stall = !en[0];
  assign rsp_valid = v[LAST];

  qa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en[0]),
    .vin       (req_valid),
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .vout      (v[0]),
    .dout      (d[0])
  );

  // divider stages
  generate
    for (i = 1; i <= QUO_W; i++) begin : g_div
      qa_div_step u_step (
        .clk  (clk),
        .rst  (rst),
        .en   (en[i]),
        .vin  (v[i-1]),
        .din  (d[i-1]),
        .vout (v[i]),
        .dout (d[i])
      );
    end
  endgenerate

  qa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en[LAST]),
    .vin            (v[QUO_W]),
    .din            (d[QUO_W]),
    .vout           (v[LAST]),
    .result_value   (result_value),
    .divide_by_zero (divide_by_zero)
  );

endmodule

// File: tb/tb_fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu
// Self-checking bench for the Q24.8 fixed-point ALU. Directed corner beats
// and random beats for every opcode go in, with random idling on the request
// side and random stall on the result side; each result beat is compared in order against a local model.
// ----------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu;
  import qa_pkg::*;

  localparam int LATENCY   = 42;
  localparam int CYCLE_CAP = 200000;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              dz;
  } alu_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [3:0]        req_type = '0;
  logic [DATA_W-1:0] operand_a = '0;
  logic [DATA_W-1:0] operand_b = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [DATA_W-1:0] result_value;
  logic              divide_by_zero;

  alu_result_t expected_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          quiet_mode = 1'b0;   // no idling or stall while set

  fixed_point_q24_8_alu dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // truncating divide of 64-bit signed values, d nonzero
  function automatic logic [63:0] trunc_div(longint n, longint d);
    longint q;
    q = n / d;
    return q;
  endfunction

  function automatic alu_result_t compute_alu(op_t op, logic [31:0] a_raw, logic [31:0] b_raw);
    alu_result_t r;
    longint      a;
    longint      b;
    longint      p;
    logic [63:0] w;
    a = longint'(signed'(a_raw));
    b = longint'(signed'(b_raw));
    r.dz = 1'b0;
    w = '0;
    case (op)
      OP_ADD:      w = a + b;
      OP_SUB:      w = a - b;
      OP_MUL: begin
        p = a * b;
        w = p >>> FRAC_BITS;
      end
      OP_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else w = trunc_div(a * (64'sd1 <<< FRAC_BITS), b);
      end
      OP_LT:       w = (a < b);
      OP_GT:       w = (a > b);
      OP_LE:       w = (a <= b);
      OP_GE:       w = (a >= b);
      OP_EQ:       w = (a == b);
      OP_NE:       w = (a != b);
      OP_MIN:      w = (a < b) ? a : b;
      OP_MAX:      w = (a > b) ? a : b;
      OP_INC:      w = a + 1;
      OP_DEC:      w = a - 1;
      OP_FROM_INT: w = a <<< FRAC_BITS;
      default:     w = trunc_div(a, 64'sd1 <<< FRAC_BITS);
    endcase
    r.value = w[31:0];
    return r;
  endfunction

  // send one beat; inputs move on the falling edge, valid stays up between
  // back-to-back beats and drops only while idling
  task automatic send_beat(op_t op, logic [31:0] a, logic [31:0] b);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 9) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_valid <= 1'b1;
    req_type  <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_results.push_back(compute_alu(op, a, b));
    @(negedge clk);
  endtask

  // result side stall pattern
  always @(negedge clk) begin
    rsp_stall <= !rst && !quiet_mode && ($urandom_range(99) < 9);
  end

  // compare each result beat
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat value=%h dz=%b", $time,
                 result_value, divide_by_zero);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_value !== exp_r.value) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_r.value,
                   result_value);
          error_count++;
        end
        if (divide_by_zero !== exp_r.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dz,
                   divide_by_zero);
          error_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return 32'(signed'($urandom_range(2048)) - 1024);
      4:       return {{24{$urandom_range(1) == 1}}, 8'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // drop valid and wait until every result is back, ending on a falling edge
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // corners: extremes, each opcode, divide by zero and overflow
  task automatic test_directed();
    logic [31:0] corner[5];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100};
    for (int op = 0; op < 16; op++) send_beat(op_t'(op), corner[op % 5], corner[(op + 2) % 5]);
    send_beat(OP_DIV, 32'h0000_0500, 32'h0);
    send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_DIV, 32'hffff_fe80, 32'h0000_0200);
    send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_beat(OP_TO_INT, 32'hffff_ff01, 32'h0);
    send_beat(OP_EQ, 32'h1234_5678, 32'h1234_5678);
    send_beat(OP_MIN, 32'h8000_0000, 32'h8000_0000);
  endtask

  // random operations, with random idling unless quiet_mode is set
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_beat(op_t'($urandom_range(15)), pick_operand(), pick_operand());
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_full_rate(int count);
    quiet_mode = 1'b1;
    test_random(count);
    wait_drained();
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();   // sender holds off until everything is back
    test_random(300);
    test_full_rate(150);
    test_random(200);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
